// File: rtl/core/xctu_pkg.sv
package xctu_pkg;

	// Byte and register widths fixed by the field formats
	localparam int DATA_W    = 8;
	localparam int REG_W     = 24;
	localparam int OPERAND_W = 32;

	// x86 near CALL and JMP opcodes
	localparam logic [DATA_W-1:0] OPC_CALL = 8'hE8;
	localparam logic [DATA_W-1:0] OPC_JMP  = 8'hE9;

	// Opcode plus its four operand bytes
	localparam int OPERAND_BYTES = 4;
	localparam int CALL_SPAN     = 5;
	localparam int MAX_RES       = 5;
	localparam int CNT_W         = 3;

	// Result queue between the step logic and the output port
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	// Configuration port
	localparam int CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_LEN  = 8'd0,
		REG_CALL_BUDGET = 8'd1,
		REG_BIG_ENDIAN  = 8'd2,
		REG_CALL_KEY    = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_SCAN    = 2'b01,
		PH_COLLECT = 2'b10
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0]  region_length;
		logic [REG_W-1:0]  call_budget;
		logic              big_endian_mode;
		logic [DATA_W-1:0] call_key;
	} cfg_t;

	// Bytes released by one input byte, count of them valid from index 0
	typedef struct packed {
		logic [CNT_W-1:0]                count;
		logic [MAX_RES-1:0][DATA_W-1:0] bytes;
	} res_t;

endpackage

// File: rtl/core/xctu_core.sv
module xctu_core import xctu_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              is_final,
	input  cfg_t              cfg,
	output res_t              res
);

	localparam int CW = ((OFFSET_BITS > REG_W) ? OFFSET_BITS : REG_W) + 1;

	logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_n;
	logic [REG_W-1:0]       calls_left_q, calls_left_n;
	phase_t                 phase_q, phase_n;
	logic [DATA_W-1:0]      held_opcode_q, held_opcode_n;
	logic [OPERAND_W-1:0]   operand_collect_q, operand_collect_n;
	logic [CNT_W-1:0]       operand_count_q, operand_count_n;
	logic [OFFSET_BITS-1:0] opcode_offset_q, opcode_offset_n;

	logic [REG_W-1:0]     calls_eff;
	logic [OPERAND_W-1:0] collect_upd;
	logic [CNT_W-1:0]     count_inc;
	logic [CW-1:0]        off_ext;
	logic                 off_sat;
	logic                 in_window;
	logic                 is_opcode;
	logic                 start_call;
	logic                 keyed_miss;
	logic [OPERAND_W-1:0] target;
	logic [OPERAND_W-1:0] new_operand;

	// Shared decode of the arriving byte
	always_comb begin
		calls_eff = (byte_offset_q == '0) ? cfg.call_budget : calls_left_q;
		collect_upd = operand_collect_q;
		collect_upd[DATA_W*operand_count_q[1:0] +: DATA_W] = data_byte;
		count_inc = operand_count_q + CNT_W'(1);
		off_ext = CW'(byte_offset_q);
		off_sat = &byte_offset_q;
		in_window = !off_sat && ((off_ext + CW'(CALL_SPAN)) < CW'(cfg.region_length));
		is_opcode = (data_byte == OPC_CALL) || (data_byte == OPC_JMP);
		start_call = is_opcode && in_window && (calls_eff != '0) && !is_final;
		keyed_miss = (operand_count_q == '0) && !cfg.big_endian_mode &&
			(data_byte != cfg.call_key);
		if (cfg.big_endian_mode) begin
			target = {collect_upd[7:0], collect_upd[15:8],
				collect_upd[23:16], collect_upd[31:24]};
		end else begin
			target = {8'h00, collect_upd[15:8], collect_upd[23:16], collect_upd[31:24]};
		end
		new_operand = target - OPERAND_W'(opcode_offset_q) - OPERAND_W'(1);
	end

	// Step: next state and released bytes
	always_comb begin
		byte_offset_n     = byte_offset_q;
		calls_left_n      = calls_left_q;
		phase_n           = phase_q;
		held_opcode_n     = held_opcode_q;
		operand_collect_n = operand_collect_q;
		operand_count_n   = operand_count_q;
		opcode_offset_n   = opcode_offset_q;
		res.count         = '0;
		res.bytes         = '0;
		if (fire) begin
			calls_left_n = calls_eff;
			if (phase_q == PH_COLLECT && keyed_miss) begin
				// Release the opcode, rescan this byte as a fresh one
				res.bytes[0] = held_opcode_q;
				phase_n = PH_SCAN;
				if (start_call) begin
					res.count = CNT_W'(1);
					phase_n = PH_COLLECT;
					held_opcode_n = data_byte;
					opcode_offset_n = byte_offset_q;
					operand_collect_n = '0;
					operand_count_n = '0;
				end else begin
					res.bytes[1] = data_byte;
					res.count = CNT_W'(2);
				end
			end else if (phase_q == PH_COLLECT) begin
				operand_collect_n = collect_upd;
				operand_count_n = count_inc;
				if (count_inc == CNT_W'(OPERAND_BYTES)) begin
					// Operand complete: rewrite it little-endian
					res.bytes[0] = held_opcode_q;
					res.bytes[1] = new_operand[7:0];
					res.bytes[2] = new_operand[15:8];
					res.bytes[3] = new_operand[23:16];
					res.bytes[4] = new_operand[31:24];
					res.count = CNT_W'(MAX_RES);
					calls_left_n = calls_eff - REG_W'(1);
					phase_n = PH_SCAN;
					operand_count_n = '0;
				end else if (is_final) begin
					// Region ends mid-operand: release everything unchanged
					res.bytes[0] = held_opcode_q;
					res.bytes[1] = collect_upd[7:0];
					res.bytes[2] = collect_upd[15:8];
					res.bytes[3] = collect_upd[23:16];
					res.count = count_inc + CNT_W'(1);
					phase_n = PH_SCAN;
					operand_count_n = '0;
				end
			end else if (start_call) begin
				// Hold the opcode until its operand is in
				phase_n = PH_COLLECT;
				held_opcode_n = data_byte;
				opcode_offset_n = byte_offset_q;
				operand_collect_n = '0;
				operand_count_n = '0;
			end else begin
				res.bytes[0] = data_byte;
				res.count = CNT_W'(1);
			end
			// Advance or restart the offset
			if (is_final) begin
				byte_offset_n = '0;
				phase_n = PH_SCAN;
				operand_count_n = '0;
			end else if (!off_sat) begin
				byte_offset_n = byte_offset_q + OFFSET_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q     <= '0;
			calls_left_q      <= '0;
			phase_q           <= PH_SCAN;
			held_opcode_q     <= '0;
			operand_collect_q <= '0;
			operand_count_q   <= '0;
			opcode_offset_q   <= '0;
		end else begin
			byte_offset_q     <= byte_offset_n;
			calls_left_q      <= calls_left_n;
			phase_q           <= phase_n;
			held_opcode_q     <= held_opcode_n;
			operand_collect_q <= operand_collect_n;
			operand_count_q   <= operand_count_n;
			opcode_offset_q   <= opcode_offset_n;
		end
	end

	// A held operand never reaches four bytes
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		operand_count_q < CNT_W'(OPERAND_BYTES))
		else $error("operand count out of range");

	// The end of a region always restarts the scan at offset zero
	a_final_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_final |=> phase_q == PH_SCAN && byte_offset_q == '0)
		else $error("region end did not restart scan");

	// Scanning never leaves operand bytes counted
	a_scan_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SCAN |-> operand_count_q == '0)
		else $error("stale operand count while scanning");

endmodule

// File: rtl/core/xctu_obuf.sv
module xctu_obuf import xctu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  res_t              res,
	output logic              room,
	output logic              tvalid,
	input  logic              tready,
	output logic [DATA_W-1:0] tdata,
	output logic              tlast
);

	typedef struct packed {
		logic              last;
		logic [DATA_W-1:0] data;
	} entry_t;

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;

	assign pop    = tvalid && tready;
	assign tvalid = (count_q != '0);
	assign tdata  = mem_q[rd_ptr_q].data;
	assign tlast  = mem_q[rd_ptr_q].last;
	// Leave space for a full call burst
	assign room   = (count_q <= QCNT_W'(QDEPTH - MAX_RES));

	// Write the released bytes in order, mark the last of the run
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (CNT_W'(i) < res.count) begin
				mem_q[wr_ptr_q + QPTR_W'(i)] <= '{
					last: (CNT_W'(i) == res.count - CNT_W'(1)),
					data: res.bytes[i]
				};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(res.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(res.count) - QCNT_W'(pop);
		end
	end

	// Occupancy never passes the queue depth
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	// Bytes arrive only when a full burst fits
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.count != '0 |-> room)
		else $error("push without room");

	// Occupancy and pointers stay consistent
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(count_q) == wr_ptr_q - rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

// File: rtl/core/x86_call_target_unfilter_unit.sv
// x86 CALL/JMP target unfilter. Bytes of a code region enter on s_axis, one per
// transaction, tlast on the final byte of the region; the restored bytes leave
// on m_axis in the same order, tlast on the last byte released by each input
// byte. An E8/E9 opcode inside the region window is held with its operand
// bytes and released as five bytes once the fourth operand byte arrives, so
// nothing comes out for those four input bytes. The unit takes one byte per
// cycle while the queue has room: the byte is registered, the step logic
// (window compare and a 32-bit subtract) pushes up to five bytes into an 8-entry
// result queue, and input is taken while the queue holds at most three bytes.
// Each byte passes the input register and the result queue. Write the four
// registers through the cfg port only while the stream is idle; the offset
// counter restarts after each tlast.
module x86_call_target_unfilter_unit import xctu_pkg::*; #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Code region in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
	input  logic                 s_axis_tlast,   // is_final
	// Restored bytes out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,   // [7:0] out_byte
	output logic                 m_axis_tlast,   // out_last
	// Register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              final_s1;
	logic              room;
	logic              fire;
	res_t              res;

	assign cfg_ready     = 1'b1;
	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_length   <= '0;
			cfg_q.call_budget     <= '0;
			cfg_q.big_endian_mode <= 1'b1;
			cfg_q.call_key        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REGION_LEN:  cfg_q.region_length   <= cfg_data;
				REG_CALL_BUDGET: cfg_q.call_budget     <= cfg_data;
				REG_BIG_ENDIAN:  cfg_q.big_endian_mode <= cfg_data[0];
				REG_CALL_KEY:    cfg_q.call_key        <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: load on a transaction, drop once processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
		end
	end

	xctu_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_s1),
		.is_final  (final_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	xctu_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.room   (room),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tlast  (m_axis_tlast)
	);

	// A held byte is processed as soon as the queue has room
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && room |=> !valid_s1 || $past(s_axis_tvalid && s_axis_tready))
		else $error("held byte not processed");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import xctu_pkg::*;

	localparam int OFF_W        = 24;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 100;

	// One byte of the stream with its end-of-run mark
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} stream_byte_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata  = '0;   // [7:0] data_byte
	logic                 s_axis_tlast  = 1'b0; // is_final
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DATA_W-1:0]    m_axis_tdata;         // [7:0] out_byte
	logic                 m_axis_tlast;         // out_last
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [REG_W-1:0]     cfg_data      = '0;

	stream_byte_t code_q[$];     // bytes waiting to be sent
	stream_byte_t restored_q[$]; // bytes the unit must still release
	int           mismatches   = 0;
	int           queued       = 0;
	int           quiet_cycles = 0;
	logic         steady       = 1'b0;

	// Register copies
	logic [REG_W-1:0]  rgn_len    = '0;
	logic [REG_W-1:0]  budget     = '0;
	logic              big_endian = 1'b1;
	logic [DATA_W-1:0] call_key   = '0;

	// Unfilter state
	logic [OFF_W-1:0]     pos        = '0;
	logic [REG_W-1:0]     calls_left = '0;
	logic                 collecting = 1'b0;
	logic [DATA_W-1:0]    held_opc   = '0;
	logic [OPERAND_W-1:0] operand    = '0;
	int                   opnd_cnt   = 0;
	logic [OFF_W-1:0]     opc_pos    = '0;

	x86_call_target_unfilter_unit #(
		.OFFSET_BITS(OFF_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Advance the unfilter by one byte and queue the bytes it releases
	function automatic void unfilter_byte(input logic [DATA_W-1:0] b, input logic fin);
		logic [DATA_W-1:0]    rel[$];
		logic [OPERAND_W-1:0] target;
		logic [OPERAND_W-1:0] value;
		logic [OFF_W-1:0]     off;
		stream_byte_t         item;
		off = pos;
		if (off == '0)
			calls_left = budget;
		// Keyed mismatch: release the opcode, then rescan this byte
		if (collecting && opnd_cnt == 0 && !big_endian && b != call_key) begin
			rel.push_back(held_opc);
			collecting = 1'b0;
		end
		if (collecting) begin
			operand[8*opnd_cnt +: 8] = b;
			opnd_cnt++;
			if (opnd_cnt == OPERAND_BYTES) begin
				if (big_endian)
					target = {operand[7:0], operand[15:8], operand[23:16], operand[31:24]};
				else
					target = {8'h00, operand[15:8], operand[23:16], operand[31:24]};
				value = target - ({{(OPERAND_W-OFF_W){1'b0}}, opc_pos} + 32'd1);
				rel.push_back(held_opc);
				for (int k = 0; k < OPERAND_BYTES; k++)
					rel.push_back(value[8*k +: 8]);
				calls_left = calls_left - 1'b1;
				collecting = 1'b0;
				opnd_cnt = 0;
			end else if (fin) begin
				// Operand cut short by the end of the region: release as is
				rel.push_back(held_opc);
				for (int k = 0; k < opnd_cnt; k++)
					rel.push_back(operand[8*k +: 8]);
				collecting = 1'b0;
				opnd_cnt = 0;
			end
		end else if ((b == OPC_CALL || b == OPC_JMP) && off != '1 &&
				({1'b0, off} + 25'd5 < {1'b0, rgn_len}) && calls_left != '0 && !fin) begin
			collecting = 1'b1;
			held_opc = b;
			opc_pos = off;
			operand = '0;
			opnd_cnt = 0;
		end else begin
			rel.push_back(b);
		end
		// Restart the offset after the final byte, saturate otherwise
		if (fin) begin
			pos = '0;
			collecting = 1'b0;
			opnd_cnt = 0;
		end else if (off != '1) begin
			pos = off + 1'b1;
		end
		for (int k = 0; k < rel.size(); k++) begin
			item.data = rel[k];
			item.last = (k == rel.size() - 1);
			restored_q.push_back(item);
		end
	endfunction

	// Drive the code stream, predicting on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin : drive
			stream_byte_t nxt;
			if (s_axis_tvalid && s_axis_tready)
				unfilter_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (code_q.size() != 0 && (steady || $urandom_range(0, 99) >= 7)) begin
					nxt = code_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.data;
					s_axis_tlast  <= nxt.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check restored bytes against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin : watch
			stream_byte_t want;
			if (m_axis_tvalid && m_axis_tready) begin
				if (restored_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = restored_q.pop_front();
					if (m_axis_tdata !== want.data)
						report_mismatch($sformatf("out_byte %02h, want %02h",
							m_axis_tdata, want.data));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("out_last %b, want %b (byte %02h)",
							m_axis_tlast, want.last, want.data));
				end
			end
			m_axis_tready <= steady || $urandom_range(0, 99) >= 7;
		end
	end

	// Drop the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_byte(input logic [DATA_W-1:0] b, input logic fin);
		stream_byte_t item;
		item.data = b;
		item.last = fin;
		code_q.push_back(item);
		queued++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_REGION_LEN:  rgn_len = val;
			REG_CALL_BUDGET: budget = val;
			REG_BIG_ENDIAN:  big_endian = val[0];
			REG_CALL_KEY:    call_key = val[DATA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [REG_W-1:0] len, input logic [REG_W-1:0] calls,
			input logic be, input logic [DATA_W-1:0] key);
		write_reg(REG_REGION_LEN, len);
		write_reg(REG_CALL_BUDGET, calls);
		write_reg(REG_BIG_ENDIAN, {{(REG_W-1){1'b0}}, be});
		write_reg(REG_CALL_KEY, {{(REG_W-DATA_W){1'b0}}, key});
		@(negedge clk);
	endtask

	// Hold until every byte is sent and released, then let the pipe empty
	task automatic settle();
		while (code_q.size() != 0 || s_axis_tvalid || restored_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Region of random bytes, mostly opcode plus operand groups
	task automatic queue_region(input int nbytes);
		logic [DATA_W-1:0] b;
		int                k;
		k = 0;
		while (k < nbytes) begin
			if ($urandom_range(0, 99) < 35) begin
				add_byte($urandom_range(0, 1) ? OPC_JMP : OPC_CALL, k == nbytes - 1);
				k++;
				for (int j = 0; j < OPERAND_BYTES && k < nbytes; j++) begin
					b = DATA_W'($urandom_range(0, 255));
					if (j == 0 && !big_endian && $urandom_range(0, 99) < 80)
						b = call_key;
					add_byte(b, k == nbytes - 1);
					k++;
				end
			end else begin
				add_byte(DATA_W'($urandom_range(0, 255)), k == nbytes - 1);
				k++;
			end
		end
	endtask

	initial begin
		logic [REG_W-1:0]  len;
		logic [REG_W-1:0]  calls;
		logic [DATA_W-1:0] key;
		int                phase_no;
		int                goal;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Widest window and budget, big-endian operands
		configure(24'hFFFFFF, 24'hFFFFFF, 1'b1, 8'h00);
		add_byte(OPC_CALL, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0); add_byte(8'h10, 1'b0);
		add_byte(OPC_JMP, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'h5A, 1'b0);
		// Region ends while the operand is still being collected
		add_byte(OPC_CALL, 1'b0); add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b1);
		// Opcode that is itself the final byte
		add_byte(OPC_CALL, 1'b1);
		settle();

		// Keyed form: opcode rejected by its key, next opcode completes on the final byte
		configure(24'd10, 24'd1, 1'b0, 8'hAA);
		add_byte(OPC_CALL, 1'b0); add_byte(OPC_JMP, 1'b0); add_byte(8'hAA, 1'b0);
		add_byte(8'h01, 1'b0); add_byte(8'h02, 1'b0); add_byte(8'h03, 1'b1);
		settle();

		// Region too short to hold a call
		configure(24'd4, 24'd3, 1'b1, 8'h00);
		add_byte(OPC_CALL, 1'b0); add_byte(8'h01, 1'b0); add_byte(8'h02, 1'b0);
		add_byte(8'h03, 1'b0); add_byte(8'h04, 1'b1);
		settle();

		// Empty window and no budget
		configure(24'd0, 24'd0, 1'b0, 8'hFF);
		add_byte(OPC_JMP, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h80, 1'b1);
		settle();

		// Random phases, each with its own register setting
		goal = queued + RANDOM_ITEMS;
		phase_no = 0;
		while (queued < goal) begin
			case ($urandom_range(0, 5))
				0:       len = '0;
				1:       len = REG_W'($urandom_range(1, 5));
				2:       len = REG_W'($urandom_range(6, 30));
				3:       len = 24'hFFFFFF;
				4:       len = REG_W'($urandom_range(0, 24'hFFFFFF));
				default: len = REG_W'($urandom_range(10, 40));
			endcase
			case ($urandom_range(0, 4))
				0:       calls = '0;
				1:       calls = 24'hFFFFFF;
				2:       calls = REG_W'($urandom_range(0, 24'hFFFFFF));
				default: calls = REG_W'($urandom_range(1, 3));
			endcase
			case ($urandom_range(0, 3))
				0:       key = 8'h00;
				1:       key = 8'hFF;
				default: key = DATA_W'($urandom_range(0, 255));
			endcase
			configure(len, calls, 1'($urandom_range(0, 1)), key);
			// One long phase runs with both sides always ready
			steady = (phase_no == 1);
			repeat (steady ? 8 : $urandom_range(2, 4))
				if (queued < goal)
					queue_region($urandom_range(1, 24));
			settle();
			steady = 1'b0;
			phase_no++;
		end

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/xctu_pkg.sv
rtl/core/xctu_core.sv
rtl/core/xctu_obuf.sv
rtl/core/x86_call_target_unfilter_unit.sv
tb/sv/tb_top.sv
